### rtl/cmc_pkg.sv
// Shared constants and types for the card machine CPU.
// No dependencies; cmc_if and the core import this package, cmc_ram does not.
`default_nettype none

package cmc_pkg;

  localparam int MEM_WORDS  = 100;
  localparam int LINE_WORDS = 10;
  localparam int ADDR_W     = 7;
  localparam int WORD_W     = 32;
  localparam int BUDGET_W   = 16;
  localparam int COUNT_W    = 6;
  localparam int LIDX_W     = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd4096;

  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_LOAD  = 2'd1;
  localparam op_t OP_RUN   = 2'd2;
  localparam op_t OP_CARD  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_NEED_CARD   = 3'd0;
  localparam status_t ST_PRINT       = 3'd1;
  localparam status_t ST_HALTED      = 3'd2;
  localparam status_t ST_BUDGET      = 3'd3;
  localparam status_t ST_BAD_ADDR    = 3'd4;
  localparam status_t ST_OUT_OF_TURN = 3'd5;

  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

endpackage

`default_nettype wire

### rtl/cmc_if.sv
// Valid/ready channel interfaces for the card machine CPU items and results.
// Depends on cmc_pkg for field widths.
`default_nettype none

interface cmc_in_if;
  import cmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] word;
  logic [7:0]        card_byte;

  modport source (output valid, output operation, output address, output word,
                  output card_byte, input ready);
  modport sink   (input valid, input operation, input address, input word,
                  input card_byte, output ready);
endinterface

interface cmc_out_if;
  import cmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [WORD_W-1:0] print_word;
  logic              last;

  modport source (output valid, output status, output print_word, output last,
                  input ready);
  modport sink   (input valid, input status, input print_word, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/card_machine_cpu_core.sv
// Card machine CPU top level: item sequencer, machine registers and result
// register around the word memory. Depends on cmc_pkg, cmc_if and cmc_ram.
//
// Timing: an item is taken in a cycle in which the sequencer is idle. Clear and load word
// items need only that cycle; a card byte for a word in memory reads that word then, and
// merges and writes it back in S_CARD_WR. A run item passes S_FETCH and S_DECODE for each
// instruction, and LR and CP add S_LOAD or S_CMP, which read their operand word. A stop at
// H, GD or a bad operand then posts its status from S_EMIT, and a stop for the budget or a
// bad fetch address passes the fetch check, then the post; PD instead passes S_PRINT_RD and
// S_PRINT_WAIT for each printed word. A run out of turn goes from idle straight to S_EMIT.
// Each cycle in which the output register is full and not being taken adds a stall to a
// post or a printed word. All of this is set by the registered read of the word memory,
// which every access goes through in turn. Clear resets the memory at once through
// per-word valid bits, so there is no clearing pass. A new item is taken whenever the
// sequencer is idle, even while the last result still waits in the output register.
`default_nettype none

module card_machine_cpu_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  cmc_in_if.sink                       in_if,
  cmc_out_if.source                    out_if,
  input  wire logic                    cfg_wr_en,
  input  wire logic [cmc_pkg::BUDGET_W-1:0] cfg_wr_data
);
  import cmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CARD_WR, S_FETCH, S_DECODE, S_LOAD, S_CMP,
    S_PRINT_RD, S_PRINT_WAIT, S_EMIT
  } state_t;

  localparam logic signed [12:0] MEM_S = 13'(MEM_WORDS);
  localparam logic signed [12:0] LIM_S = 13'(MEM_WORDS - LINE_WORDS);
  localparam logic [COUNT_W-1:0] LINE_BYTES = COUNT_W'(LINE_WORDS * 4);
  localparam logic [LIDX_W-1:0]  LAST_IDX = LIDX_W'(LINE_WORDS - 1);

  function automatic logic [WORD_W-1:0] blank_zero(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = w;
    for (int i = 0; i < 4; i++) begin
      if (w[8*i +: 8] == 8'd0) begin
        r[8*i +: 8] = CH_SPACE;
      end
    end
    return r;
  endfunction

  state_t               state_r, state_nxt;
  logic [WORD_W-1:0]    acc_r, acc_nxt;
  logic                 flag_r, flag_nxt;
  logic [ADDR_W-1:0]    ic_r, ic_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_W-1:0]    base_r, base_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 halted_r, halted_nxt;
  logic [BUDGET_W-1:0]  budget_r;
  logic [BUDGET_W-1:0]  steps_r, steps_nxt;
  logic [ADDR_W-1:0]    pbase_r, pbase_nxt;
  logic [LIDX_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]    wi_r, wi_nxt;
  logic [7:0]           byte_r, byte_nxt;
  status_t              res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [WORD_W-1:0]    out_word_r, out_word_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_clr, ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  logic                 accept, slot_free;
  logic [7:0]           opc;
  logic signed [12:0]   hi, lo, v;
  logic                 v_in;
  logic [ADDR_W:0]      wi;
  logic [COUNT_W-1:0]   count_inc;
  logic [WORD_W-1:0]    merged;

  cmc_ram #(.DEPTH(MEM_WORDS), .WIDTH(WORD_W)) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ram_clr),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready       = (state_r == S_IDLE);
  assign accept            = in_if.valid && in_if.ready;
  assign slot_free         = !out_valid_r || out_if.ready;
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.print_word = out_word_r;
  assign out_if.last       = out_last_r;

  // Operand decode of the fetched word, ten times the high digit by shifts.
  assign opc  = ram_rdata[31:24];
  assign hi   = $signed({5'd0, ram_rdata[15:8]}) - $signed({5'd0, CH_ZERO});
  assign lo   = $signed({5'd0, ram_rdata[7:0]}) - $signed({5'd0, CH_ZERO});
  assign v    = (hi <<< 3) + (hi <<< 1) + lo;
  assign v_in = !v[12] && (v < MEM_S);

  assign wi        = {1'b0, base_r} + (ADDR_W+1)'(count_r[COUNT_W-1:2]);
  assign count_inc = count_r + 1'b1;

  always_comb begin
    merged = ram_rdata;
    case (count_r[1:0])
      2'd0:    merged[31:24] = byte_r;
      2'd1:    merged[23:16] = byte_r;
      2'd2:    merged[15:8]  = byte_r;
      default: merged[7:0]   = byte_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    flag_nxt       = flag_r;
    ic_nxt         = ic_r;
    pend_nxt       = pend_r;
    base_nxt       = base_r;
    count_nxt      = count_r;
    halted_nxt     = halted_r;
    steps_nxt      = steps_r;
    pbase_nxt      = pbase_r;
    idx_nxt        = idx_r;
    wi_nxt         = wi_r;
    byte_nxt       = byte_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    ram_clr        = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_if.operation)
            OP_CLEAR: begin
              ram_clr    = 1'b1;
              acc_nxt    = '0;
              flag_nxt   = 1'b0;
              ic_nxt     = '0;
              pend_nxt   = 1'b0;
              base_nxt   = '0;
              count_nxt  = '0;
              halted_nxt = 1'b0;
            end
            OP_LOAD: begin
              ram_we    = (in_if.address < ADDR_W'(MEM_WORDS));
              ram_waddr = in_if.address;
              ram_wdata = in_if.word;
            end
            OP_RUN: begin
              if (halted_r || pend_r) begin
                res_nxt   = ST_OUT_OF_TURN;
                state_nxt = S_EMIT;
              end else begin
                steps_nxt = '0;
                state_nxt = S_FETCH;
              end
            end
            default: begin
              if (!pend_r) begin
                res_nxt   = ST_OUT_OF_TURN;
                state_nxt = S_EMIT;
              end else if (in_if.card_byte == CH_NL) begin
                pend_nxt = 1'b0;
              end else if (wi < (ADDR_W+1)'(MEM_WORDS)) begin
                // Read the target word now, merge the byte next cycle.
                ram_re    = 1'b1;
                ram_raddr = wi[ADDR_W-1:0];
                wi_nxt    = wi[ADDR_W-1:0];
                byte_nxt  = in_if.card_byte;
                state_nxt = S_CARD_WR;
              end else begin
                count_nxt = count_inc;
                pend_nxt  = (count_inc < LINE_BYTES);
              end
            end
          endcase
        end
      end
      S_CARD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wi_r;
        ram_wdata = merged;
        count_nxt = count_inc;
        pend_nxt  = (count_inc < LINE_BYTES);
        state_nxt = S_IDLE;
      end
      S_FETCH: begin
        if (steps_r >= budget_r) begin
          res_nxt   = ST_BUDGET;
          state_nxt = S_EMIT;
        end else if (ic_r >= ADDR_W'(MEM_WORDS)) begin
          halted_nxt = 1'b1;
          res_nxt    = ST_BAD_ADDR;
          state_nxt  = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ic_r;
          ic_nxt    = ic_r + 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FETCH;
        case (opc)
          CH_L, CH_C: begin
            if (!v_in) begin
              halted_nxt = 1'b1;
              res_nxt    = ST_BAD_ADDR;
              state_nxt  = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = v[ADDR_W-1:0];
              state_nxt = (opc == CH_L) ? S_LOAD : S_CMP;
            end
          end
          CH_S: begin
            if (!v_in) begin
              halted_nxt = 1'b1;
              res_nxt    = ST_BAD_ADDR;
              state_nxt  = S_EMIT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = v[ADDR_W-1:0];
              ram_wdata = acc_r;
            end
          end
          CH_B: begin
            if (flag_r) begin
              if (!v_in) begin
                halted_nxt = 1'b1;
                res_nxt    = ST_BAD_ADDR;
                state_nxt  = S_EMIT;
              end else begin
                // A target of zero wraps the counter to its top value.
                ic_nxt   = v[ADDR_W-1:0] - 1'b1;
                flag_nxt = 1'b0;
              end
            end
          end
          CH_H: begin
            halted_nxt = 1'b1;
            res_nxt    = ST_HALTED;
            state_nxt  = S_EMIT;
          end
          CH_G, CH_P: begin
            if (!v_in || (v > LIM_S)) begin
              halted_nxt = 1'b1;
              res_nxt    = ST_BAD_ADDR;
              state_nxt  = S_EMIT;
            end else if (opc == CH_G) begin
              pend_nxt  = 1'b1;
              base_nxt  = v[ADDR_W-1:0];
              count_nxt = '0;
              res_nxt   = ST_NEED_CARD;
              state_nxt = S_EMIT;
            end else begin
              pbase_nxt = v[ADDR_W-1:0];
              idx_nxt   = '0;
              state_nxt = S_PRINT_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_LOAD: begin
        acc_nxt   = ram_rdata;
        state_nxt = S_FETCH;
      end
      S_CMP: begin
        flag_nxt  = (ram_rdata == acc_r);
        state_nxt = S_FETCH;
      end
      S_PRINT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pbase_r + ADDR_W'(idx_r);
        state_nxt = S_PRINT_WAIT;
      end
      S_PRINT_WAIT: begin
        // Read data holds until the next read, so waiting on the output is safe.
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_PRINT;
          out_word_nxt   = blank_zero(ram_rdata);
          out_last_nxt   = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_PRINT_RD;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_word_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      flag_r      <= 1'b0;
      ic_r        <= '0;
      pend_r      <= 1'b0;
      base_r      <= '0;
      count_r     <= '0;
      halted_r    <= 1'b0;
      budget_r    <= BUDGET_RESET;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      flag_r      <= flag_nxt;
      ic_r        <= ic_nxt;
      pend_r      <= pend_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      halted_r    <= halted_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pbase_r      <= pbase_nxt;
    idx_r        <= idx_nxt;
    wi_r         <= wi_nxt;
    byte_r       <= byte_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
  end

  // The single memory never reads and writes one word in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("memory read and write to the same word in one cycle");

  a_oot_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_if.operation == OP_RUN && (halted_r || pend_r))
      |=> (state_r == S_EMIT && res_r == ST_OUT_OF_TURN))
    else $error("run out of turn did not post its status");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_PRINT) |-> out_last_r)
    else $error("single-result status without last");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (count_r < LINE_BYTES))
    else $error("card line still pending past its length");

  a_halt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !pend_r)
    else $error("machine halted while a card line is pending");

endmodule

`default_nettype wire

### rtl/cmc_ram.sv
// Single-port-read, single-port-write RAM with registered read data and
// per-entry valid bits; an entry never written since clear reads as zero.
`default_nettype none

module cmc_ram #(
  parameter int DEPTH = 100,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     clr,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire
